/* rtl/core/ctf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctf_pkg
// Types and codes shared by the checksummed frame transmitter.
// ----------------------------------------------------------------------------
package ctf_pkg;

  localparam int NumResults = 3;

  typedef enum logic {
    OP_START = 1'b0,
    OP_DATA  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BUSY     = 2'd1,
    ST_NO_FRAME = 2'd2
  } status_t;

  typedef enum logic {
    REG_FRAME_ID    = 1'b0,
    REG_CHAR_OFFSET = 1'b1
  } reg_index_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] frame_length;
    logic [7:0]  data_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       frame_done;
    status_t    status;
    logic       last;
  } result_t;

  localparam logic [7:0] FrameIdReset    = 8'd9;
  localparam logic [7:0] CharOffsetReset = 8'd48;

endpackage
`default_nettype wire

/* rtl/core/checksummed_frame_transmitter.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// checksummed_frame_transmitter
// Length-prefixed byte framer with an additive 8-bit checksum.
// ----------------------------------------------------------------------------
// The first result is valid in the cycle after the item transfer.
// One result per cycle while result_stall is low. A start queues three results
// (one if a frame is active), a closing payload byte two, any other item one.
// The next item is taken in the cycle the last pending result transfers.
// Reset: rst (synchronous) clears the frame state, empties the result queue
// and restores frame_id to 9 and char_offset to 48.
module checksummed_frame_transmitter (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire ctf_pkg::reg_index_t wr_index,
  input  wire logic [7:0]       wr_data,
  input  wire logic             item_valid,
  output logic                  item_stall,
  input  wire ctf_pkg::item_t   item,
  output logic                  result_valid,
  input  wire logic             result_stall,
  output ctf_pkg::result_t      result
);
  import ctf_pkg::*;

  logic [7:0]  frame_id;
  logic [7:0]  char_offset;
  logic        active;
  logic        active_next;
  logic [15:0] remaining;
  logic [15:0] remaining_next;
  logic [7:0]  running_sum;
  logic [7:0]  running_sum_next;

  result_t     queue [NumResults];
  result_t     queue_next [NumResults];
  logic [1:0]  count;
  logic [1:0]  count_next;

  logic        item_xfer;
  logic        result_xfer;
  logic [7:0]  sum_add;
  logic [15:0] remaining_dec;

  assign result_valid = (count != 2'd0);
  assign result       = queue[0];
  assign result_xfer  = result_valid && !result_stall;
  assign item_stall   = !((count == 2'd0) || ((count == 2'd1) && result_xfer));
  assign item_xfer    = item_valid && !item_stall;

  assign sum_add       = running_sum + item.data_byte;
  assign remaining_dec = remaining - 16'd1;

  always_comb begin
    active_next      = active;
    remaining_next   = remaining;
    running_sum_next = running_sum;
    count_next       = 2'd0;
    for (int i = 0; i < NumResults; i++) begin
      queue_next[i] = '0;
    end
    if (item.op == OP_START) begin
      if (active) begin
        queue_next[0].status = ST_BUSY;
        queue_next[0].last   = 1'b1;
        count_next           = 2'd1;
      end else begin
        queue_next[0].out_byte   = frame_id + char_offset;
        queue_next[0].byte_valid = 1'b1;
        queue_next[1].out_byte   = item.frame_length[15:8] + char_offset;
        queue_next[1].byte_valid = 1'b1;
        queue_next[2].out_byte   = item.frame_length[7:0] + char_offset;
        queue_next[2].byte_valid = 1'b1;
        queue_next[2].frame_done = (item.frame_length == 16'd0);
        queue_next[2].last       = 1'b1;
        count_next               = 2'd3;
        running_sum_next         = 8'd0;
        remaining_next           = item.frame_length;
        active_next              = (item.frame_length != 16'd0);
      end
    end else if (!active) begin
      queue_next[0].status = ST_NO_FRAME;
      queue_next[0].last   = 1'b1;
      count_next           = 2'd1;
    end else begin
      remaining_next           = remaining_dec;
      queue_next[0].out_byte   = item.data_byte;
      queue_next[0].byte_valid = 1'b1;
      if (remaining_dec != 16'd0) begin
        queue_next[0].last = 1'b1;
        running_sum_next   = sum_add;
        count_next         = 2'd1;
      end else begin
        queue_next[1].out_byte   = sum_add + char_offset;
        queue_next[1].byte_valid = 1'b1;
        queue_next[1].frame_done = 1'b1;
        queue_next[1].last       = 1'b1;
        running_sum_next         = 8'd0;
        active_next              = 1'b0;
        count_next               = 2'd2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_id    <= FrameIdReset;
      char_offset <= CharOffsetReset;
    end else if (wr_en) begin
      case (wr_index)
        REG_FRAME_ID:    frame_id    <= wr_data;
        REG_CHAR_OFFSET: char_offset <= wr_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      remaining   <= 16'd0;
      running_sum <= 8'd0;
      count       <= 2'd0;
    end else if (item_xfer) begin
      active      <= active_next;
      remaining   <= remaining_next;
      running_sum <= running_sum_next;
      count       <= count_next;
    end else if (result_xfer) begin
      count <= count - 2'd1;
    end
  end

  // load on item transfer, else advance on result transfer
  always_ff @(posedge clk) begin
    if (item_xfer) begin
      for (int i = 0; i < NumResults; i++) begin
        queue[i] <= queue_next[i];
      end
    end else if (result_xfer) begin
      for (int i = 0; i < NumResults - 1; i++) begin
        queue[i] <= queue[i + 1];
      end
      queue[NumResults - 1] <= '0;
    end
  end

endmodule
`default_nettype wire
